/* sv/assert_macros.svh */
// Assertion helpers, included by the top module to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define TKSK_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define TKSK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/tksk_pkg.sv */
package tksk_pkg;

  // Input operations.
  localparam logic OP_OFFER = 1'b0;
  localparam logic OP_DUMP  = 1'b1;

  // Result kinds.
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_ENTRY  = 1'b1;

  // Controller states.
  localparam int  STATE_BITS = 1;
  localparam logic [STATE_BITS-1:0] ST_IDLE = 1'b0;
  localparam logic [STATE_BITS-1:0] ST_DUMP = 1'b1;

  // Commands broadcast to every cell of the row.
  typedef struct packed {
    logic offer;   // insert the candidate into the row
    logic rotate;  // move every stored entry one rank toward the head
  } tksk_op_t;

  // Per-cell position flags, worked out from the fill level and the capacity.
  typedef struct packed {
    logic occ;     // the cell holds a stored entry
    logic grow;    // the cell is the first free one and the list is not full
    logic wrap;    // the cell holds the tail entry
  } tksk_slot_t;

endpackage

/* sv/top_k_score_keeper_top.sv */
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    operation, cand_id, cand_score
// out       output     out_valid / out_ready  kind, accepted, evicted, evicted_id,
//                                             entry_valid, entry_id, entry_score,
//                                             drop_total, last
// config    input      keep_count_we          keep_count_data
//
// An offer is handled by the whole row at once: every cell compares and shifts together.
// A dump of n stored entries gives n beats, one beat per turn of the cell row; an
// empty dump gives one. The next item is taken once the last beat is loaded.
// Reset is synchronous and clears the fill level, drop count, lock and controller;
// the cells need no clearing. A stalled output beat holds the row and the input.
`include "assert_macros.svh"

module top_k_score_keeper_top #(
  parameter int MAX_KEEP   = 16,
  parameter int ID_BITS    = 16,
  parameter int SCORE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  keep_count_we,
  input  logic [4:0]            keep_count_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  operation,
  input  logic [ID_BITS-1:0]    cand_id,
  input  logic [SCORE_BITS-1:0] cand_score,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  kind,
  output logic                  accepted,
  output logic                  evicted,
  output logic [ID_BITS-1:0]    evicted_id,
  output logic                  entry_valid,
  output logic [ID_BITS-1:0]    entry_id,
  output logic [SCORE_BITS-1:0] entry_score,
  output logic [31:0]           drop_total,
  output logic                  last
);

  localparam int FW = $clog2(MAX_KEEP + 1);
  localparam logic [FW-1:0] KEEP_MAX = FW'(MAX_KEEP);

  logic [FW-1:0] fill_level, fill_level_next;
  logic [FW-1:0] keep_count;
  logic          cfg_locked;
  logic [31:0]   drop_count, drop_count_next;
  logic [tksk_pkg::STATE_BITS-1:0] state, state_next;
  logic [FW-1:0] dump_cnt, dump_cnt_next;

  logic [ID_BITS-1:0]    cell_id    [MAX_KEEP];
  logic [SCORE_BITS-1:0] cell_score [MAX_KEEP];
  logic [MAX_KEEP-1:0]   cell_ge;
  tksk_pkg::tksk_slot_t  cell_slot  [MAX_KEEP];
  tksk_pkg::tksk_op_t    row_op;

  logic                  in_fire, load, produce;
  logic                  offer_fire, dump_fire;
  logic                  full, tail_ge, drop, evict;
  logic [ID_BITS-1:0]    tail_id;
  logic [FW-1:0]         emit_idx;
  logic                  last_entry;

  // Configuration: clamp to 1..MAX_KEEP, ignored once the first offer is in.
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= KEEP_MAX;
    end else if (keep_count_we && !cfg_locked) begin
      if (keep_count_data == 5'd0) begin
        keep_count <= FW'(1);
      end else if (32'(keep_count_data) > 32'(MAX_KEEP)) begin
        keep_count <= KEEP_MAX;
      end else begin
        keep_count <= FW'(keep_count_data);
      end
    end
  end

  // Handshakes: the output register is refilled when empty or being drained.
  assign load       = !out_valid || out_ready;
  assign in_ready   = (state == tksk_pkg::ST_IDLE) && load;
  assign in_fire    = in_valid && in_ready;
  assign offer_fire = in_fire && (operation == tksk_pkg::OP_OFFER);
  assign dump_fire  = in_fire && (operation == tksk_pkg::OP_DUMP);

  // Tail entry of the list, picked out by its position flag.
  always_comb begin
    tail_id = '0;
    tail_ge = 1'b0;
    for (int i = 0; i < MAX_KEEP; i++) begin
      if (cell_slot[i].wrap) begin
        tail_id = tail_id | cell_id[i];
        tail_ge = tail_ge | cell_ge[i];
      end
    end
  end

  assign full  = (fill_level == keep_count);
  assign drop  = full && tail_ge;
  assign evict = full && !tail_ge;

  assign row_op.offer  = offer_fire && !drop;
  assign row_op.rotate = (dump_fire && (fill_level != '0))
                      || ((state == tksk_pkg::ST_DUMP) && load);

  // Row of cells, head at index zero.
  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    logic                  prev_ge;
    logic [ID_BITS-1:0]    prev_id, next_id;
    logic [SCORE_BITS-1:0] prev_score, next_score;

    assign cell_slot[i].occ  = FW'(i) < fill_level;
    assign cell_slot[i].grow = (FW'(i) == fill_level) && !full;
    assign cell_slot[i].wrap = (FW'(i + 1) == fill_level);

    if (i == 0) begin : g_head
      assign prev_ge    = 1'b1;
      assign prev_id    = cand_id;
      assign prev_score = cand_score;
    end else begin : g_body
      assign prev_ge    = cell_ge[i-1];
      assign prev_id    = cell_id[i-1];
      assign prev_score = cell_score[i-1];
    end

    if (i == MAX_KEEP - 1) begin : g_tail
      assign next_id    = cell_id[0];
      assign next_score = cell_score[0];
    end else begin : g_inner
      assign next_id    = cell_id[i+1];
      assign next_score = cell_score[i+1];
    end

    tksk_cell #(
      .ID_BITS    (ID_BITS),
      .SCORE_BITS (SCORE_BITS)
    ) u_cell (
      .clk        (clk),
      .op         (row_op),
      .slot       (cell_slot[i]),
      .cand_id    (cand_id),
      .cand_score (cand_score),
      .prev_ge    (prev_ge),
      .prev_id    (prev_id),
      .prev_score (prev_score),
      .next_id    (next_id),
      .next_score (next_score),
      .head_id    (cell_id[0]),
      .head_score (cell_score[0]),
      .ge         (cell_ge[i]),
      .id_q       (cell_id[i]),
      .score_q    (cell_score[i])
    );
  end

  // Fill level and the saturating drop counter.
  always_comb begin
    fill_level_next = fill_level;
    drop_count_next = drop_count;
    if (offer_fire && !full) begin
      fill_level_next = fill_level + FW'(1);
    end
    if (offer_fire && full && (drop_count != '1)) begin
      drop_count_next = drop_count + 32'd1;
    end
  end

  // Dump sequencing: the head cell always carries the next entry to send.
  assign emit_idx   = (state == tksk_pkg::ST_IDLE) ? '0 : dump_cnt;
  assign last_entry = ((emit_idx + FW'(1)) == fill_level);

  always_comb begin
    state_next    = state;
    dump_cnt_next = dump_cnt;
    case (state)
      tksk_pkg::ST_IDLE: begin
        if (dump_fire && (fill_level != '0) && !last_entry) begin
          state_next    = tksk_pkg::ST_DUMP;
          dump_cnt_next = FW'(1);
        end
      end
      tksk_pkg::ST_DUMP: begin
        if (load) begin
          if (last_entry) begin
            state_next = tksk_pkg::ST_IDLE;
          end else begin
            dump_cnt_next = dump_cnt + FW'(1);
          end
        end
      end
      default: begin
        state_next = tksk_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_level <= '0;
      drop_count <= '0;
      cfg_locked <= 1'b0;
      state      <= tksk_pkg::ST_IDLE;
      dump_cnt   <= '0;
    end else begin
      fill_level <= fill_level_next;
      drop_count <= drop_count_next;
      state      <= state_next;
      dump_cnt   <= dump_cnt_next;
      if (offer_fire) begin
        cfg_locked <= 1'b1;
      end
    end
  end

  // Output register: one beat per offer, per dump entry, or per empty dump.
  assign produce = in_fire || (state == tksk_pkg::ST_DUMP);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= produce;
    end
  end

  always_ff @(posedge clk) begin
    if (load && produce) begin
      drop_total <= drop_count_next;
      if (offer_fire) begin
        kind        <= tksk_pkg::KIND_STATUS;
        accepted    <= !drop;
        evicted     <= evict;
        evicted_id  <= evict ? tail_id : '0;
        entry_valid <= 1'b0;
        entry_id    <= '0;
        entry_score <= '0;
        last        <= 1'b1;
      end else if (fill_level == '0) begin
        kind        <= tksk_pkg::KIND_ENTRY;
        accepted    <= 1'b0;
        evicted     <= 1'b0;
        evicted_id  <= '0;
        entry_valid <= 1'b0;
        entry_id    <= '0;
        entry_score <= '0;
        last        <= 1'b1;
      end else begin
        kind        <= tksk_pkg::KIND_ENTRY;
        accepted    <= 1'b0;
        evicted     <= 1'b0;
        evicted_id  <= '0;
        entry_valid <= 1'b1;
        entry_id    <= cell_id[0];
        entry_score <= cell_score[0];
        last        <= last_entry;
      end
    end
  end

  // Checks on the list bookkeeping and the dump sequencer.
  `TKSK_ASSERT(a_fill_bounded, clk, rst, (fill_level <= keep_count), "fill level above capacity")
  `TKSK_ASSERT(a_fill_grows, clk, rst, (offer_fire && !full) |=> (fill_level == $past(fill_level) + FW'(1)), "offer into a list with room did not grow it")
  `TKSK_ASSERT(a_cfg_frozen, clk, rst, cfg_locked |=> $stable(keep_count), "capacity changed after the first offer")
  `TKSK_ASSERT(a_dump_in_range, clk, rst, (state == tksk_pkg::ST_DUMP) |-> ((dump_cnt != '0) && (dump_cnt < fill_level)), "dump rank outside the stored entries")

endmodule

/* sv/tksk_cell.sv */
module tksk_cell #(
  parameter int ID_BITS    = 16,
  parameter int SCORE_BITS = 16
) (
  input  logic                  clk,
  input  tksk_pkg::tksk_op_t    op,
  input  tksk_pkg::tksk_slot_t  slot,
  input  logic [ID_BITS-1:0]    cand_id,
  input  logic [SCORE_BITS-1:0] cand_score,
  // Neighbor toward the head.
  input  logic                  prev_ge,
  input  logic [ID_BITS-1:0]    prev_id,
  input  logic [SCORE_BITS-1:0] prev_score,
  // Neighbor toward the tail, and the head entry for the wrap-around.
  input  logic [ID_BITS-1:0]    next_id,
  input  logic [SCORE_BITS-1:0] next_score,
  input  logic [ID_BITS-1:0]    head_id,
  input  logic [SCORE_BITS-1:0] head_score,
  output logic                  ge,
  output logic [ID_BITS-1:0]    id_q,
  output logic [SCORE_BITS-1:0] score_q
);

  // A stored entry at least as good as the candidate stays ahead of it.
  assign ge = slot.occ && (score_q >= cand_score);

  // Keep, take the candidate, or take the entry pushed down from the head side.
  // During a dump the row turns like a ring over the stored entries.
  always_ff @(posedge clk) begin
    if (op.offer && (slot.occ || slot.grow) && !ge) begin
      if (prev_ge) begin
        id_q    <= cand_id;
        score_q <= cand_score;
      end else begin
        id_q    <= prev_id;
        score_q <= prev_score;
      end
    end else if (op.rotate && slot.occ) begin
      if (slot.wrap) begin
        id_q    <= head_id;
        score_q <= head_score;
      end else begin
        id_q    <= next_id;
        score_q <= next_score;
      end
    end
  end

endmodule

/* test/tb_top_k_score_keeper_top.sv */
module tb_top_k_score_keeper_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_KEEP = 16;
  localparam int SHOWN_ERRORS = 10;

  // One output beat, laid out as the block presents it.
  typedef struct packed {
    logic        kind;
    logic        accepted;
    logic        evicted;
    logic [15:0] evicted_id;
    logic        entry_valid;
    logic [15:0] entry_id;
    logic [15:0] entry_score;
    logic [31:0] drop_total;
    logic        last;
  } keeper_beat_t;

  // Tracks the ranked list as the block should hold it and the beats it owes.
  class rank_scoreboard;
    logic [15:0]  held_id [MAX_KEEP];
    logic [15:0]  held_score [MAX_KEEP];
    int unsigned  held_count;
    int unsigned  capacity;
    logic [31:0]  losses;
    bit           locked;
    keeper_beat_t owed_q [$];
    int unsigned  errors;

    function new();
      held_count = 0;
      capacity = MAX_KEEP;
      losses = '0;
      locked = 1'b0;
      errors = 0;
    endfunction

    // Capacity writes are clamped to 1..MAX_KEEP and frozen by the first offer.
    function void write_capacity(logic [4:0] value);
      if (locked) return;
      if (value == 0) capacity = 1;
      else if (value > MAX_KEEP) capacity = MAX_KEEP;
      else capacity = value;
    endfunction

    function void count_loss();
      if (losses != '1) losses++;
    endfunction

    // Queues one owed beat behind the others.
    function void owe_beat(keeper_beat_t b);
      owed_q.insert(owed_q.size(), b);
    endfunction

    // Works out the beats that one accepted input item causes.
    function void note_item(logic op, logic [15:0] id, logic [15:0] score);
      keeper_beat_t b;
      int unsigned n;
      int unsigned pos;
      b = '0;
      if (op == tksk_pkg::OP_DUMP) begin
        b.kind = tksk_pkg::KIND_ENTRY;
        b.drop_total = losses;
        if (held_count == 0) begin
          b.last = 1'b1;
          owe_beat(b);
          return;
        end
        for (int unsigned i = 0; i < held_count; i++) begin
          b.entry_valid = 1'b1;
          b.entry_id = held_id[i];
          b.entry_score = held_score[i];
          b.last = (i + 1 == held_count);
          owe_beat(b);
        end
        return;
      end

      locked = 1'b1;
      b.kind = tksk_pkg::KIND_STATUS;
      b.last = 1'b1;
      n = (held_count < capacity) ? held_count : capacity;

      // A full list rejects anything not strictly above its tail.
      if (n >= capacity) begin
        if (score <= held_score[n-1]) begin
          count_loss();
          b.drop_total = losses;
          owe_beat(b);
          return;
        end
        b.evicted = 1'b1;
        b.evicted_id = held_id[n-1];
        n--;
        count_loss();
      end

      // Equal scores stay ahead of the newcomer.
      pos = 0;
      while (pos < n && held_score[pos] >= score) pos++;
      for (int unsigned i = n; i > pos; i--) begin
        held_id[i] = held_id[i-1];
        held_score[i] = held_score[i-1];
      end
      held_id[pos] = id;
      held_score[pos] = score;
      held_count = n + 1;
      b.accepted = 1'b1;
      b.drop_total = losses;
      owe_beat(b);
    endfunction

    function void check_beat(keeper_beat_t got);
      keeper_beat_t want;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= SHOWN_ERRORS)
          $display("unexpected output beat: kind %0d id %h score %h last %0d",
                   got.kind, got.entry_id, got.entry_score, got.last);
        return;
      end
      want = owed_q[0];
      owed_q.delete(0);
      if (got !== want) begin
        errors++;
        if (errors <= SHOWN_ERRORS) begin
          $write("beat mismatch (expected/actual): kind %0d/%0d accepted %0d/%0d ",
                 want.kind, got.kind, want.accepted, got.accepted);
          $write("evicted %0d/%0d evicted_id %h/%h entry_valid %0d/%0d ",
                 want.evicted, got.evicted, want.evicted_id, got.evicted_id,
                 want.entry_valid, got.entry_valid);
          $display("entry_id %h/%h entry_score %h/%h drop_total %0d/%0d last %0d/%0d",
                   want.entry_id, got.entry_id, want.entry_score, got.entry_score,
                   want.drop_total, got.drop_total, want.last, got.last);
        end
      end
    endfunction

    function int unsigned outstanding();
      return owed_q.size();
    endfunction

    function void close_out();
      if (owed_q.size() != 0) begin
        errors++;
        $display("%0d expected beats never arrived", owed_q.size());
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        keep_count_we;
  logic [4:0]  keep_count_data;
  logic        in_valid;
  logic        in_ready;
  logic        operation;
  logic [15:0] cand_id;
  logic [15:0] cand_score;
  logic        out_valid;
  logic        out_ready;
  logic        kind;
  logic        accepted;
  logic        evicted;
  logic [15:0] evicted_id;
  logic        entry_valid;
  logic [15:0] entry_id;
  logic [15:0] entry_score;
  logic [31:0] drop_total;
  logic        last;
  bit          steady;

  rank_scoreboard sb = new();

  top_k_score_keeper_top uut (
    .clk             (clk),
    .rst             (rst),
    .keep_count_we   (keep_count_we),
    .keep_count_data (keep_count_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .operation       (operation),
    .cand_id         (cand_id),
    .cand_score      (cand_score),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .kind            (kind),
    .accepted        (accepted),
    .evicted         (evicted),
    .evicted_id      (evicted_id),
    .entry_valid     (entry_valid),
    .entry_id        (entry_id),
    .entry_score     (entry_score),
    .drop_total      (drop_total),
    .last            (last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The receiver stalls at random except during the steady stretch.
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 28);
  end

  // Every beat taken from the block is checked against the oldest expectation.
  always @(posedge clk) begin : out_watch
    keeper_beat_t got;
    if (!rst && out_valid && out_ready) begin
      got.kind = kind;
      got.accepted = accepted;
      got.evicted = evicted;
      got.evicted_id = evicted_id;
      got.entry_valid = entry_valid;
      got.entry_id = entry_id;
      got.entry_score = entry_score;
      got.drop_total = drop_total;
      got.last = last;
      sb.check_beat(got);
    end
  end

  // Presents one input beat, with random idle cycles ahead of it outside the steady stretch.
  task automatic send_item(logic op, logic [15:0] id, logic [15:0] score);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    cand_id <= id;
    cand_score <= score;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(op, id, score);
  endtask

  // Holds the input back until every owed beat has come out.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_keep(logic [4:0] value);
    @(negedge clk);
    keep_count_we <= 1'b1;
    keep_count_data <= value;
    @(negedge clk);
    keep_count_we <= 1'b0;
    sb.write_capacity(value);
  endtask

  initial begin
    int unsigned pick;
    logic [15:0] score;
    logic [4:0]  cap;
    rst = 1'b1;
    keep_count_we = 1'b0;
    keep_count_data = '0;
    in_valid = 1'b0;
    operation = tksk_pkg::OP_OFFER;
    cand_id = '0;
    cand_score = '0;
    out_ready = 1'b0;
    steady = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // A dump of the empty list, then capacity writes while nothing is locked.
    send_item(tksk_pkg::OP_DUMP, 16'($urandom), 16'($urandom));
    settle();
    write_keep(5'd0);
    write_keep(5'd31);
    write_keep(5'd16);
    pick = $urandom_range(0, 3);
    cap = (pick == 0) ? 5'd1 : (pick == 1) ? 5'd16 : 5'($urandom_range(2, 15));
    write_keep(cap);

    // Extremes, a zero score into a list with room, and equal scores.
    send_item(tksk_pkg::OP_OFFER, 16'h0000, 16'h0000);
    send_item(tksk_pkg::OP_OFFER, 16'hffff, 16'hffff);
    send_item(tksk_pkg::OP_OFFER, 16'h1234, 16'h0000);
    send_item(tksk_pkg::OP_OFFER, 16'h00ff, 16'h8000);
    send_item(tksk_pkg::OP_OFFER, 16'hff00, 16'h8000);
    send_item(tksk_pkg::OP_DUMP, 16'h5a5a, 16'ha5a5);

    // Fill the list, then offer the tail score, zero and the top score; equal or lower drop, higher evicts.
    while (sb.held_count < sb.capacity)
      send_item(tksk_pkg::OP_OFFER, 16'(16'h0100 + sb.held_count),
                16'(16'h4000 + sb.held_count));
    send_item(tksk_pkg::OP_OFFER, 16'hbeef, sb.held_score[sb.held_count-1]);
    send_item(tksk_pkg::OP_OFFER, 16'hcafe, 16'h0000);
    send_item(tksk_pkg::OP_OFFER, 16'hface, 16'hffff);
    send_item(tksk_pkg::OP_DUMP, 16'h0000, 16'h0000);

    // Writes after the first offer must leave the capacity alone.
    settle();
    write_keep(5'd1);
    write_keep(5'd31);

    // Random offers and dumps with a share of tied and extreme scores.
    for (int i = 0; i < 200; i++) begin
      if (i == 40) steady = 1'b1;
      if (i == 100) steady = 1'b0;
      if (i == 130) begin
        settle();
        write_keep(5'($urandom));
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) score = 16'($urandom_range(0, 15));
      else if (pick < 50 && sb.held_count > 0)
        score = sb.held_score[$urandom_range(0, sb.held_count - 1)];
      else if (pick < 65) score = 16'($urandom_range(16'hf000, 16'hffff));
      else score = 16'($urandom);
      if ($urandom_range(0, 99) < 10) send_item(tksk_pkg::OP_DUMP, 16'($urandom), score);
      else send_item(tksk_pkg::OP_OFFER, 16'($urandom), score);
    end

    settle();
    sb.close_out();
    if (sb.errors == 0) begin
      $display("top_k_score_keeper_top verification clean");
    end else begin
      $display("top_k_score_keeper_top verification failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #3_000_000;
    $display("top_k_score_keeper_top verification failed");
    $finish;
  end

endmodule

/* top_k_score_keeper_top.f */
+incdir+sv
sv/tksk_pkg.sv
sv/tksk_cell.sv
sv/top_k_score_keeper_top.sv
test/tb_top_k_score_keeper_top.sv
